// ===== hw/rtl/pscc_pkg.sv =====
package pscc_pkg;

    localparam int MdW      = 64;
    localparam int MdCntW   = $clog2(MdW + 1);
    localparam int MulSteps = 20;
    localparam int DivSteps = MdW;
    localparam int CfgW     = 20;
    localparam int CfgIdxW  = 3;

    localparam logic [14:0] RefMinMv    = 15'd800;
    localparam logic [14:0] RefMaxConv  = 15'h7FFF;
    localparam logic [3:0]  RefStepMv   = 4'd10;
    localparam logic [11:0] RefMaxCode  = 12'hFFF;
    localparam logic [8:0]  IlimStepUv  = 9'd500;
    localparam logic [8:0]  IlimHalfUv  = 9'd250;
    localparam logic [9:0]  UvPerMv     = 10'd1000;
    localparam logic [8:0]  UvPerMvHalf = 9'd500;
    localparam logic [18:0] IlimStepNa  = 19'd500000;
    localparam logic [6:0]  IlimMaxCode = 7'h7F;
    localparam logic        IlimEnable  = 1'b1;
    localparam logic [6:0]  ModeBase    = 7'h62;
    localparam logic [11:0] DacMaxCode  = 12'd4095;
    localparam logic [15:0] LdoMaxMv    = 16'hFFFF;

    localparam logic [10:0] RstLdoOffset = 11'd1000;
    localparam logic [12:0] RstFbRef     = 13'd1205;
    localparam logic [19:0] RstTopRes    = 20'd20000;
    localparam logic [19:0] RstBotRes    = 20'd2000;
    localparam logic [19:0] RstTrimRes   = 20'd3600;
    localparam logic [12:0] RstDacSupply = 13'd3300;
    localparam logic [15:0] RstSense     = 16'd10000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_LDO_OFFSET = 3'd0,
        CFG_FB_REF     = 3'd1,
        CFG_TOP_RES    = 3'd2,
        CFG_BOT_RES    = 3'd3,
        CFG_TRIM_RES   = 3'd4,
        CFG_DAC_SUPPLY = 3'd5,
        CFG_SENSE      = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        MD_MUL = 1'b0,
        MD_DIV = 1'b1
    } t_md_op;

    typedef struct packed {
        logic   start;
        t_md_op op;
    } t_md_req;

    typedef struct packed {
        logic done;
    } t_md_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_REF,
        S_P1,
        S_P2,
        S_M,
        S_D,
        S_QDAC,
        S_DCM,
        S_DCD,
        S_X,
        S_Y,
        S_Z,
        S_DEN,
        S_QV,
        S_PI,
        S_C1,
        S_CODE,
        S_AM,
        S_AD,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/power_setpoint_code_converter_top.sv =====
// Computation: each input transaction runs through one shared bit-serial
//   multiply/divide unit (11 multiplies of 20 steps, 7 divides of 64 steps),
//   then the result is loaded into the output register.
// Flow: a new transaction is taken only once the previous one is loaded;
//   loading waits while an earlier result is stalled, and a finished result
//   waits in the output register while the next transaction is taken.
// Reset: synchronous, active low; control and configuration registers return to defaults, history clears.
module power_setpoint_code_converter_top
    import pscc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [14:0]        i_target_mv,
    input  logic [15:0]        i_target_ma,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [11:0]        o_vsel_code,
    output logic [7:0]         o_ilim_byte,
    output logic [7:0]         o_mode_byte,
    output logic [11:0]        o_trim_word,
    output logic [12:0]        o_dac_mv,
    output logic               o_dac_saturated,
    output logic [14:0]        o_applied_mv,
    output logic [15:0]        o_applied_ma,
    output logic [15:0]        o_ldo_expected_mv,
    output logic               o_output_on,
    output logic               o_write_needed
);

    logic [10:0] r_offset;
    logic [12:0] r_vfb;
    logic [19:0] r_rt_raw;
    logic [19:0] r_rb_raw;
    logic [19:0] r_rd_raw;
    logic [12:0] r_vdd_raw;
    logic [15:0] r_uohm_raw;

    logic [19:0] w_rt;
    logic [19:0] w_rb;
    logic [19:0] w_rd;
    logic [12:0] w_vdd;
    logic [15:0] w_uohm;

    t_state r_state;
    t_state n_state;
    logic   r_issued;

    logic [14:0] r_held_mv;
    logic [15:0] r_held_ma;
    logic        r_applied;

    logic [14:0]    r_tmv;
    logic [15:0]    r_tma;
    logic           r_on;
    logic           r_need;
    logic [14:0]    r_conv;
    logic [11:0]    r_ref;
    logic [MdW-1:0] r_p1;
    logic [MdW-1:0] r_mag;
    logic           r_neg;
    logic [MdW-1:0] r_den;
    logic [12:0]    r_dmv;
    logic           r_sat;
    logic [11:0]    r_dcode;
    logic [15:0]    r_lexp;
    logic [6:0]     r_code;
    logic [15:0]    r_ama;

    logic r_ov;
    logic w_load;
    logic w_in_acc;

    t_md_req        w_md_req;
    t_md_rsp        w_md_rsp;
    logic [MdW-1:0] w_md_a;
    logic [MdW-1:0] w_md_b;
    logic [MdW-1:0] w_res;

    logic signed [16:0] w_s;
    logic [15:0]        w_s_abs;
    logic signed [14:0] w_t;
    logic [13:0]        w_t_abs;
    logic signed [MdW:0]   w_comb;
    logic signed [MdW+1:0] w_v;
    logic [15:0]        w_conv_sum;
    logic [14:0]        w_conv;

    assign w_rt   = (r_rt_raw == '0) ? 20'd1 : r_rt_raw;
    assign w_rb   = (r_rb_raw == '0) ? 20'd1 : r_rb_raw;
    assign w_rd   = (r_rd_raw == '0) ? 20'd1 : r_rd_raw;
    assign w_vdd  = (r_vdd_raw == '0) ? 13'd1 : r_vdd_raw;
    assign w_uohm = (r_uohm_raw == '0) ? 16'd1 : r_uohm_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= RstLdoOffset;
            r_vfb      <= RstFbRef;
            r_rt_raw   <= RstTopRes;
            r_rb_raw   <= RstBotRes;
            r_rd_raw   <= RstTrimRes;
            r_vdd_raw  <= RstDacSupply;
            r_uohm_raw <= RstSense;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LDO_OFFSET: r_offset   <= i_cfg_data[10:0];
                CFG_FB_REF:     r_vfb      <= i_cfg_data[12:0];
                CFG_TOP_RES:    r_rt_raw   <= i_cfg_data;
                CFG_BOT_RES:    r_rb_raw   <= i_cfg_data;
                CFG_TRIM_RES:   r_rd_raw   <= i_cfg_data;
                CFG_DAC_SUPPLY: r_vdd_raw  <= i_cfg_data[12:0];
                CFG_SENSE:      r_uohm_raw <= i_cfg_data[15:0];
                default:        r_offset   <= r_offset;
            endcase
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign w_in_acc = i_valid && !o_stall;

    assign w_conv_sum = {1'b0, i_target_mv} + {5'b0, r_offset};
    always_comb begin
        w_conv = w_conv_sum[15] ? RefMaxConv : w_conv_sum[14:0];
        if (w_conv < RefMinMv) begin
            w_conv = RefMinMv;
        end
        if (i_target_mv == '0) begin
            w_conv = '0;
        end
    end

    assign w_s     = $signed({2'b0, r_tmv}) - $signed({4'b0, r_vfb});
    assign w_s_abs = w_s[16] ? 16'(-w_s) : w_s[15:0];
    assign w_t     = $signed({2'b0, r_dmv}) - $signed({2'b0, r_vfb});
    assign w_t_abs = w_t[14] ? 14'(-w_t) : w_t[13:0];

    always_comb begin
        if (r_neg) begin
            w_comb = $signed({1'b0, r_p1}) + $signed({1'b0, w_res});
        end else begin
            w_comb = $signed({1'b0, r_p1}) - $signed({1'b0, w_res});
        end
    end

    always_comb begin
        if (r_neg) begin
            w_v = $signed({(MdW - 11)'(0), r_vfb}) - $signed({2'b0, w_res});
        end else begin
            w_v = $signed({(MdW - 11)'(0), r_vfb}) + $signed({2'b0, w_res});
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_REF;
            S_REF:  if (w_md_rsp.done) n_state = S_P1;
            S_P1:   if (w_md_rsp.done) n_state = S_P2;
            S_P2:   if (w_md_rsp.done) n_state = S_M;
            S_M:    if (w_md_rsp.done) n_state = S_D;
            S_D:    if (w_md_rsp.done) n_state = S_QDAC;
            S_QDAC: if (w_md_rsp.done) n_state = S_DCM;
            S_DCM:  if (w_md_rsp.done) n_state = S_DCD;
            S_DCD:  if (w_md_rsp.done) n_state = S_X;
            S_X:    if (w_md_rsp.done) n_state = S_Y;
            S_Y:    if (w_md_rsp.done) n_state = S_Z;
            S_Z:    if (w_md_rsp.done) n_state = S_DEN;
            S_DEN:  if (w_md_rsp.done) n_state = S_QV;
            S_QV:   if (w_md_rsp.done) n_state = S_PI;
            S_PI:   if (w_md_rsp.done) n_state = S_C1;
            S_C1:   if (w_md_rsp.done) n_state = S_CODE;
            S_CODE: if (w_md_rsp.done) n_state = S_AM;
            S_AM:   if (w_md_rsp.done) n_state = S_AD;
            S_AD:   if (w_md_rsp.done) n_state = S_OUT;
            S_OUT:  if (!r_ov || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_md_req.start = (r_state != S_IDLE) && (r_state != S_OUT) && !r_issued;
        w_md_req.op    = MD_MUL;
        w_md_a         = '0;
        w_md_b         = '0;
        w_load         = 1'b0;
        unique case (r_state)
            S_IDLE: w_md_req.start = 1'b0;
            S_REF: begin
                w_md_req.op = MD_DIV;
                w_md_a = r_on ? MdW'(r_conv - RefMinMv) : '0;
                w_md_b = MdW'(RefStepMv);
            end
            S_P1: begin
                w_md_a = MdW'(r_vfb);
                w_md_b = MdW'(w_rt);
            end
            S_P2: begin
                w_md_a = MdW'(w_s_abs);
                w_md_b = MdW'(w_rb);
            end
            S_M: begin
                w_md_a = r_mag;
                w_md_b = MdW'(w_rd);
            end
            S_D: begin
                w_md_a = MdW'(w_rb);
                w_md_b = MdW'(w_rt);
            end
            S_QDAC, S_QV: begin
                w_md_req.op = MD_DIV;
                w_md_a = r_mag + (r_den >> 1);
                w_md_b = r_den;
            end
            S_DCM: begin
                w_md_a = MdW'(r_dmv);
                w_md_b = MdW'(DacMaxCode);
            end
            S_DCD: begin
                w_md_req.op = MD_DIV;
                w_md_a = r_mag + MdW'(w_vdd >> 1);
                w_md_b = MdW'(w_vdd);
            end
            S_X: begin
                w_md_a = MdW'(r_vfb);
                w_md_b = MdW'(w_rd);
            end
            S_Y: begin
                w_md_a = MdW'(w_t_abs);
                w_md_b = MdW'(w_rb);
            end
            S_Z: begin
                w_md_a = r_mag;
                w_md_b = MdW'(w_rt);
            end
            S_DEN: begin
                w_md_a = MdW'(w_rb);
                w_md_b = MdW'(w_rd);
            end
            S_PI: begin
                w_md_a = MdW'(r_tma);
                w_md_b = MdW'(w_uohm);
            end
            S_C1: begin
                w_md_req.op = MD_DIV;
                w_md_a = r_mag + MdW'(UvPerMvHalf);
                w_md_b = MdW'(UvPerMv);
            end
            S_CODE: begin
                w_md_req.op = MD_DIV;
                w_md_a = r_mag + MdW'(IlimHalfUv);
                w_md_b = MdW'(IlimStepUv);
            end
            S_AM: begin
                w_md_a = MdW'(r_code);
                w_md_b = MdW'(IlimStepNa);
            end
            S_AD: begin
                w_md_req.op = MD_DIV;
                w_md_a = r_mag + MdW'(w_uohm >> 1);
                w_md_b = MdW'(w_uohm);
            end
            S_OUT: begin
                w_md_req.start = 1'b0;
                w_load = !r_ov || !i_stall;
            end
            default: w_md_req.start = 1'b0;
        endcase
    end

    pscc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .i_a     (w_md_a),
        .i_b     (w_md_b),
        .o_rsp   (w_md_rsp),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issued  <= 1'b0;
            r_held_mv <= '0;
            r_held_ma <= '0;
            r_applied <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_md_rsp.done) begin
                r_issued <= 1'b0;
            end else if (w_md_req.start) begin
                r_issued <= 1'b1;
            end
            if (w_in_acc) begin
                r_held_mv <= i_target_mv;
                r_held_ma <= i_target_ma;
                r_applied <= 1'b1;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_tmv  <= i_target_mv;
            r_tma  <= i_target_ma;
            r_on   <= (i_target_mv != '0);
            r_conv <= w_conv;
            r_need <= !r_applied || (i_target_mv != r_held_mv) || (i_target_ma != r_held_ma);
            r_neg  <= 1'b0;
        end
        if (w_md_rsp.done) begin
            unique case (r_state)
                S_REF: begin
                    r_ref <= (w_res > MdW'(RefMaxCode)) ? RefMaxCode : w_res[11:0];
                    if (!r_on) r_ref <= '0;
                    r_neg <= w_s[16];
                end
                S_P1, S_X: r_p1 <= w_res;
                S_P2, S_Y: begin
                    r_neg <= w_comb[MdW];
                    r_mag <= w_comb[MdW] ? MdW'(-w_comb) : w_comb[MdW-1:0];
                end
                S_M, S_Z, S_DCM, S_PI, S_C1, S_AM: r_mag <= w_res;
                S_D, S_DEN: r_den <= w_res;
                S_QDAC: begin
                    if (w_v < 0) begin
                        r_dmv <= '0;
                        r_sat <= 1'b1;
                    end else if (w_v > $signed({(MdW - 11)'(0), w_vdd})) begin
                        r_dmv <= w_vdd;
                        r_sat <= 1'b1;
                    end else begin
                        r_dmv <= w_v[12:0];
                        r_sat <= 1'b0;
                    end
                end
                S_DCD: begin
                    r_dcode <= (w_res > MdW'(DacMaxCode)) ? DacMaxCode : w_res[11:0];
                    r_neg   <= w_t[14];
                end
                S_QV: begin
                    if (w_v < 0) begin
                        r_lexp <= '0;
                    end else if (w_v > $signed({(MdW - 14)'(0), LdoMaxMv})) begin
                        r_lexp <= LdoMaxMv;
                    end else begin
                        r_lexp <= w_v[15:0];
                    end
                end
                S_CODE: r_code <= (w_res > MdW'(IlimMaxCode)) ? IlimMaxCode : w_res[6:0];
                S_AD: r_ama <= (w_res > MdW'(LdoMaxMv)) ? LdoMaxMv : w_res[15:0];
                default: r_mag <= r_mag;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_vsel_code       <= r_ref;
            o_ilim_byte       <= {IlimEnable, r_code};
            o_mode_byte       <= {r_on, ModeBase};
            o_trim_word       <= r_dcode;
            o_dac_mv          <= r_dmv;
            o_dac_saturated   <= r_sat;
            o_applied_mv      <= r_conv;
            o_applied_ma      <= r_ama;
            o_ldo_expected_mv <= r_lexp;
            o_output_on       <= r_on;
            o_write_needed    <= r_need;
        end
    end

    assign o_valid = r_ov;

    a_done_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_rsp.done |-> (r_state != S_IDLE) && (r_state != S_OUT))
        else $error("arithmetic unit finished outside a computation");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_REF) && !r_issued)
        else $error("accepted transaction did not start computation");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && r_ov && i_stall |=> (r_state == S_OUT))
        else $error("finished result dropped while output stalled");

    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issued |-> (r_state != S_IDLE) && (r_state != S_OUT))
        else $error("operation pending while sequencer idle");

endmodule

// ===== hw/rtl/pscc_muldiv.sv =====
module pscc_muldiv
    import pscc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_md_req        i_req,
    input  logic [MdW-1:0] i_a,
    input  logic [MdW-1:0] i_b,
    output t_md_rsp        o_rsp,
    output logic [MdW-1:0] o_res
);

    logic              r_busy;
    logic              r_done;
    t_md_op            r_op;
    logic [MdCntW-1:0] r_cnt;
    logic [MdW-1:0]    r_a;
    logic [MdW-1:0]    r_b;
    logic [MdW-1:0]    r_acc;

    logic [MdW-1:0] w_sum;
    logic [MdW-1:0] w_rem;
    logic           w_ge;
    logic [MdW-1:0] w_diff;

    assign w_sum  = r_acc + (r_b[0] ? r_a : '0);
    assign w_rem  = {r_acc[MdW-2:0], r_a[MdW-1]};
    assign w_ge   = (w_rem >= r_b);
    assign w_diff = w_rem - r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= MD_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= (i_req.op == MD_MUL) ? MdCntW'(MulSteps) : MdCntW'(DivSteps);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MdCntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            unique case (r_op)
                MD_MUL: begin
                    r_acc <= w_sum;
                    r_a   <= {r_a[MdW-2:0], 1'b0};
                    r_b   <= {1'b0, r_b[MdW-1:1]};
                end
                MD_DIV: begin
                    r_acc <= w_ge ? w_diff : w_rem;
                    r_a   <= {r_a[MdW-2:0], w_ge};
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_res      = (r_op == MD_MUL) ? r_acc : r_a;

endmodule

// ===== dv/power_setpoint_code_converter_checker.sv =====
`timescale 1ns / 1ps
module power_setpoint_code_converter_checker
    import pscc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic [14:0]        i_target_mv,
    input  logic [15:0]        i_target_ma,
    input  logic               i_valid_out,
    input  logic               i_stall_out,
    input  logic [11:0]        i_vsel_code,
    input  logic [7:0]         i_ilim_byte,
    input  logic [7:0]         i_mode_byte,
    input  logic [11:0]        i_trim_word,
    input  logic [12:0]        i_dac_mv,
    input  logic               i_dac_saturated,
    input  logic [14:0]        i_applied_mv,
    input  logic [15:0]        i_applied_ma,
    input  logic [15:0]        i_ldo_expected_mv,
    input  logic               i_output_on,
    input  logic               i_write_needed,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_sat_seen
);

    typedef struct {
        logic [11:0] vsel_code;
        logic [7:0]  ilim_byte;
        logic [7:0]  mode_byte;
        logic [11:0] trim_word;
        logic [12:0] dac_mv;
        logic        dac_saturated;
        logic [14:0] applied_mv;
        logic [15:0] applied_ma;
        logic [15:0] ldo_expected_mv;
        logic        output_on;
        logic        write_needed;
    } t_setpoint_codes;

    t_setpoint_codes codes_q[$];

    logic [10:0] ldo_offset;
    logic [12:0] fb_ref;
    logic [19:0] top_res;
    logic [19:0] bot_res;
    logic [19:0] trim_res;
    logic [12:0] dac_supply;
    logic [15:0] sense;
    logic [14:0] held_mv;
    logic [15:0] held_ma;
    logic        held_valid;

    function automatic longint round_away_div(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint nonzero(longint v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic t_setpoint_codes convert_setpoint(logic [14:0] tmv, logic [15:0] tma);
        t_setpoint_codes r;
        longint vfb, rt, rb, rd, vdd, uohm, conv, num, dac, vout, code, ama, dcode;
        bit on, sat;
        vfb  = fb_ref;
        rt   = nonzero(top_res);
        rb   = nonzero(bot_res);
        rd   = nonzero(trim_res);
        vdd  = nonzero(dac_supply);
        uohm = nonzero(sense);
        on   = (tmv != 0);
        sat  = 0;
        conv = 0;
        r.vsel_code = '0;
        if (on) begin
            conv = longint'(tmv) + ldo_offset;
            if (conv > 32767) conv = 32767;
            if (conv < 800) conv = 800;
            r.vsel_code = ((conv - 800) / 10 > 4095) ? 12'd4095 : 12'((conv - 800) / 10);
        end
        num = vfb * rt - (longint'(tmv) - vfb) * rb;
        dac = vfb + round_away_div(rd * num, rb * rt);
        if (dac < 0) begin
            dac = 0;
            sat = 1;
        end else if (dac > vdd) begin
            dac = vdd;
            sat = 1;
        end
        dcode = (dac * 4095 + vdd / 2) / vdd;
        if (dcode > 4095) dcode = 4095;
        num  = vfb * rt * rd - (dac - vfb) * rt * rb;
        vout = vfb + round_away_div(num, rb * rd);
        if (vout < 0) vout = 0;
        if (vout > 65535) vout = 65535;
        code = ((longint'(tma) * uohm + 500) / 1000 + 250) / 500;
        if (code > 127) code = 127;
        ama = (code * 500000 + uohm / 2) / uohm;
        if (ama > 65535) ama = 65535;
        r.ilim_byte       = {IlimEnable, 7'(code)};
        r.mode_byte       = {on, ModeBase};
        r.trim_word       = 12'(dcode);
        r.dac_mv          = 13'(dac);
        r.dac_saturated   = sat;
        r.applied_mv      = 15'(conv);
        r.applied_ma      = 16'(ama);
        r.ldo_expected_mv = 16'(vout);
        r.output_on       = on;
        r.write_needed    = !held_valid || tmv != held_mv || tma != held_ma;
        return r;
    endfunction

    task automatic compare_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_setpoint_codes e;
        if (!i_rst_n) begin
            ldo_offset <= RstLdoOffset;
            fb_ref     <= RstFbRef;
            top_res    <= RstTopRes;
            bot_res    <= RstBotRes;
            trim_res   <= RstTrimRes;
            dac_supply <= RstDacSupply;
            sense      <= RstSense;
            held_mv    <= '0;
            held_ma    <= '0;
            held_valid <= 1'b0;
            codes_q.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_sat_seen   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LDO_OFFSET: ldo_offset <= i_cfg_data[10:0];
                    CFG_FB_REF:     fb_ref     <= i_cfg_data[12:0];
                    CFG_TOP_RES:    top_res    <= i_cfg_data;
                    CFG_BOT_RES:    bot_res    <= i_cfg_data;
                    CFG_TRIM_RES:   trim_res   <= i_cfg_data;
                    CFG_DAC_SUPPLY: dac_supply <= i_cfg_data[12:0];
                    CFG_SENSE:      sense      <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_valid_out && !i_stall_out) begin
                if (codes_q.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    o_fail_count++;
                end else begin
                    e = codes_q.pop_front();
                    compare_field("vsel_code", e.vsel_code, i_vsel_code);
                    compare_field("ilim_byte", e.ilim_byte, i_ilim_byte);
                    compare_field("mode_byte", e.mode_byte, i_mode_byte);
                    compare_field("trim_word", e.trim_word, i_trim_word);
                    compare_field("dac_mv", e.dac_mv, i_dac_mv);
                    compare_field("dac_saturated", e.dac_saturated, i_dac_saturated);
                    compare_field("applied_mv", e.applied_mv, i_applied_mv);
                    compare_field("applied_ma", e.applied_ma, i_applied_ma);
                    compare_field("ldo_expected_mv", e.ldo_expected_mv, i_ldo_expected_mv);
                    compare_field("output_on", e.output_on, i_output_on);
                    compare_field("write_needed", e.write_needed, i_write_needed);
                    o_checked++;
                    if (e.dac_saturated) o_sat_seen++;
                end
            end
            if (i_valid && !i_stall_in) begin
                codes_q.push_back(convert_setpoint(i_target_mv, i_target_ma));
                held_mv    <= i_target_mv;
                held_ma    <= i_target_ma;
                held_valid <= 1'b1;
            end
        end
        o_pending = codes_q.size();
    end

endmodule

// ===== dv/power_setpoint_code_converter_top_tb.sv =====
`timescale 1ns / 1ps
module power_setpoint_code_converter_top_tb;
    import pscc_pkg::*;

    localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;
    localparam int SettleCycles = 800;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [CfgW-1:0]    i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [14:0]        i_target_mv = '0;
    logic [15:0]        i_target_ma = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [11:0]        o_vsel_code;
    logic [7:0]         o_ilim_byte;
    logic [7:0]         o_mode_byte;
    logic [11:0]        o_trim_word;
    logic [12:0]        o_dac_mv;
    logic               o_dac_saturated;
    logic [14:0]        o_applied_mv;
    logic [15:0]        o_applied_ma;
    logic [15:0]        o_ldo_expected_mv;
    logic               o_output_on;
    logic               o_write_needed;

    int fail_count, pending, checked, sat_seen;
    bit quiet;
    int sent;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    power_setpoint_code_converter_top u_top (.*);

    power_setpoint_code_converter_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_target_mv(i_target_mv), .i_target_ma(i_target_ma),
        .i_valid_out(o_valid), .i_stall_out(i_stall),
        .i_vsel_code(o_vsel_code), .i_ilim_byte(o_ilim_byte), .i_mode_byte(o_mode_byte),
        .i_trim_word(o_trim_word), .i_dac_mv(o_dac_mv), .i_dac_saturated(o_dac_saturated),
        .i_applied_mv(o_applied_mv), .i_applied_ma(o_applied_ma),
        .i_ldo_expected_mv(o_ldo_expected_mv), .i_output_on(o_output_on),
        .i_write_needed(o_write_needed),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_checked(checked), .o_sat_seen(sat_seen)
    );

    always @(negedge i_clk) begin
        i_stall <= quiet ? 1'b0 : ($urandom_range(99) < 7);
    end

    task automatic send_setpoint(logic [14:0] mv, logic [15:0] ma);
        if (!quiet && $urandom_range(99) < 7) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(5)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_target_mv <= mv;
        i_target_ma <= ma;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_settings(int off, int fb, int rt, int rb, int rd, int vdd, int sn);
        write_reg(CFG_LDO_OFFSET, CfgW'(off));
        write_reg(CFG_FB_REF, CfgW'(fb));
        write_reg(CFG_TOP_RES, CfgW'(rt));
        write_reg(CFG_BOT_RES, CfgW'(rb));
        write_reg(CFG_TRIM_RES, CfgW'(rd));
        write_reg(CFG_DAC_SUPPLY, CfgW'(vdd));
        write_reg(CFG_SENSE, CfgW'(sn));
    endtask

    task automatic random_burst(int count);
        logic [14:0] mv;
        logic [15:0] ma;
        mv = '0;
        ma = '0;
        repeat (count) begin
            case ($urandom_range(9))
                0, 1:    ;
                2:       mv = 15'($urandom);
                3:       ma = 16'($urandom);
                4:       mv = 15'($urandom_range(800));
                5:       ma = 16'($urandom_range(2000));
                default: begin
                    mv = 15'($urandom_range(20000));
                    ma = 16'($urandom);
                end
            endcase
            send_setpoint(mv, ma);
        end
    endtask

    initial begin
        quiet = 1'b0;
        sent  = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, output off, repeats, saturation
        send_setpoint(15'd0, 16'd0);
        send_setpoint(15'd0, 16'd0);
        send_setpoint(15'd1, 16'd1);
        send_setpoint(15'd5000, 16'd3000);
        send_setpoint(15'd5000, 16'd3000);
        send_setpoint(15'd20000, 16'd65535);
        send_setpoint(15'h7FFF, 16'hFFFF);
        send_setpoint(15'h7FFF, 16'd0);
        send_setpoint(15'd12, 16'd24);
        send_setpoint(15'd799, 16'd25);
        send_setpoint(15'h5555, 16'hAAAA);
        send_setpoint(15'h2AAA, 16'h5555);
        send_setpoint(15'd1205, 16'd12700);
        drain_results();

        // extremes: zero registers act as one, unused index ignored
        load_settings(2000, 1, 0, 0, 0, 0, 0);
        write_reg(CfgIdxUnused, 20'hFFFFF);
        send_setpoint(15'd0, 16'd0);
        send_setpoint(15'h7FFF, 16'hFFFF);
        send_setpoint(15'd100, 16'd1);
        drain_results();
        load_settings(0, 5000, 1000, 1000000, 1000000, 5500, 1);
        send_setpoint(15'd0, 16'd0);
        send_setpoint(15'd20000, 16'd1);
        send_setpoint(15'h7FFF, 16'hFFFF);
        drain_results();
        load_settings(1000, 600, 1000000, 1, 1000, 1, 65535);
        send_setpoint(15'd3300, 16'd65535);
        send_setpoint(15'd0, 16'd100);
        drain_results();

        load_settings(1000, 1205, 20000, 2000, 3600, 3300, 10000);
        random_burst(180);
        drain_results();
        quiet = 1'b1;
        random_burst(120);
        quiet = 1'b0;
        drain_results();
        load_settings($urandom_range(2000), $urandom_range(500, 2000),
                      $urandom_range(1000, 200000), $urandom_range(500, 50000),
                      $urandom_range(500, 50000), $urandom_range(1000, 5500),
                      $urandom_range(1, 65535));
        random_burst(170);
        drain_results();
        load_settings(0, 800, 10000, 10000, 10000, 5000, 500);
        random_burst(150);
        drain_results();

        $display("Checked %0d of %0d setpoint transactions over 7 register settings,",
                 checked, sent);
        $display("%0d with the DAC voltage clamped.", sat_seen);
        if (fail_count == 0) begin
            $display("power_setpoint_code_converter_top verification clean");
        end else begin
            $display("power_setpoint_code_converter_top verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("power_setpoint_code_converter_top verification failed");
        $finish;
    end

endmodule
